@@ rtl/xaad_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xaad_pkg - XA-ADPCM stereo nibble decoder shared definitions
// Word types, filter coefficient tables and the per-channel sample decode.
// ----------------------------------------------------------------------------
package xaad_pkg;

   // Rounding term and divide-by-64 shift of the prediction
   localparam int RoundBias = 32;
   localparam int DivShift  = 6;

   // Input word: two block headers and one packed data byte
   typedef struct packed {
      logic [7:0] left_hdr;
      logic [7:0] right_hdr;
      logic [7:0] packed_byte;
   } req_word_type;

   // Output word: one decoded stereo sample pair
   typedef struct packed {
      logic signed [15:0] left_pcm;
      logic signed [15:0] right_pcm;
   } rsp_word_type;

   // Coefficient applied to the last output
   function automatic logic signed [7:0] coef_last(input logic [1:0] filter);
      logic signed [7:0] coef;
      unique case (filter)
         2'd0:    coef = 8'sd0;
         2'd1:    coef = 8'sd60;
         2'd2:    coef = 8'sd115;
         default: coef = 8'sd98;
      endcase
      return coef;
   endfunction

   // Coefficient applied to the output before the last
   function automatic logic signed [7:0] coef_before(input logic [1:0] filter);
      logic signed [7:0] coef;
      unique case (filter)
         2'd0:    coef = 8'sd0;
         2'd1:    coef = 8'sd0;
         2'd2:    coef = -8'sd52;
         default: coef = -8'sd55;
      endcase
      return coef;
   endfunction

   // Decode one 4-bit sample of one channel against its two-sample history
   function automatic logic signed [15:0] decode_nibble(
      input logic [7:0]         header,
      input logic [3:0]         nibble,
      input logic signed [15:0] last,
      input logic signed [15:0] prior
   );
      logic [3:0]         shift;
      logic [1:0]         filter;
      logic signed [15:0] scaled;
      logic signed [23:0] prod_last;
      logic signed [23:0] prod_before;
      logic signed [24:0] pred;
      logic signed [17:0] quot;
      logic signed [18:0] sum;
      logic signed [15:0] sample;

      shift  = header[3:0];
      filter = header[5:4];

      // nibble sits at bits 15:12, then arithmetic shift (not capped)
      scaled = $signed({nibble, 12'h000}) >>> shift;

      prod_last   = coef_last(filter) * last;
      prod_before = coef_before(filter) * prior;
      pred = 25'(prod_last) + 25'(prod_before) + 25'(RoundBias);

      // divide by 64, truncating toward zero
      if (pred[24]) begin
         quot = 18'((pred + 25'((1 << DivShift) - 1)) >>> DivShift);
      end else begin
         quot = 18'(pred >>> DivShift);
      end

      sum = 19'(scaled) + 19'(quot);

      // saturate to signed 16 bits
      if (sum > 19'sd32767) begin
         sample = 16'sh7fff;
      end else if (sum < -19'sd32768) begin
         sample = 16'sh8000;
      end else begin
         sample = sum[15:0];
      end
      return sample;
   endfunction

endpackage

@@ rtl/xaad_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xaad_stream_if - valid/ready channels of the stereo decoder
// Input channel carries headers and the packed byte, output the PCM pair.
// ----------------------------------------------------------------------------
interface xaad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_hdr;
   logic [7:0] right_hdr;
   logic [7:0] packed_byte;

   modport source (output valid, output left_hdr, output right_hdr,
                   output packed_byte, input ready);
   modport sink   (input valid, input left_hdr, input right_hdr,
                   input packed_byte, output ready);
endinterface

interface xaad_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_pcm;
   logic signed [15:0] right_pcm;

   modport source (output valid, output left_pcm, output right_pcm, input ready);
   modport sink   (input valid, input left_pcm, input right_pcm, output ready);
endinterface

@@ rtl/xa_adpcm_stereo_nibble_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xa_adpcm_stereo_nibble_decoder - 4-bit stereo XA-ADPCM sample pair decoder
// Decodes one left and one right nibble per word with per-channel history.
//
//   channel    direction  word contents
//   req_chan   in         left_hdr, right_hdr, packed_byte
//   rsp_chan   out        left_pcm, right_pcm
//
// One word a cycle sustained while rsp_chan stays ready; each word passes the
// input register and then the result register before it shows on rsp_chan.
// The decode of both channels sits between the input and result registers,
// including the history update that the next word depends on.
// Synchronous reset clears both valid flags and all history to zero.
// A stalled output holds its word; the input register still takes a word
// while the output waits, then ready drops until the output moves.
// ----------------------------------------------------------------------------
module xa_adpcm_stereo_nibble_decoder (
   input logic       clock,
   input logic       reset,
   xaad_req_if.sink  req_chan,
   xaad_rsp_if.source rsp_chan
);

   // Holding registers
   logic                  in_valid_ff,  in_valid_in;
   xaad_pkg::req_word_type in_word_ff,  in_word_in;
   logic                  out_valid_ff, out_valid_in;
   xaad_pkg::rsp_word_type out_word_ff, out_word_in;

   // Two-sample history per channel
   logic signed [15:0] left_last_ff,   left_last_in;
   logic signed [15:0] left_before_ff, left_before_in;
   logic signed [15:0] right_last_ff,  right_last_in;
   logic signed [15:0] right_before_ff, right_before_in;

   logic               advance;
   logic               req_take;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;

   // Pipeline control
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Per-channel decode of the held word
   assign left_sample  = xaad_pkg::decode_nibble(in_word_ff.left_hdr,
                                                 in_word_ff.packed_byte[3:0],
                                                 left_last_ff, left_before_ff);
   assign right_sample = xaad_pkg::decode_nibble(in_word_ff.right_hdr,
                                                 in_word_ff.packed_byte[7:4],
                                                 right_last_ff, right_before_ff);

   // Next-state logic
   always_comb begin
      in_valid_in     = in_valid_ff;
      in_word_in      = in_word_ff;
      out_valid_in    = out_valid_ff;
      out_word_in     = out_word_ff;
      left_last_in    = left_last_ff;
      left_before_in  = left_before_ff;
      right_last_in   = right_last_ff;
      right_before_in = right_before_ff;

      if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in           = 1'b0;
         out_valid_in          = 1'b1;
         out_word_in.left_pcm  = left_sample;
         out_word_in.right_pcm = right_sample;
         left_before_in        = left_last_ff;
         left_last_in          = left_sample;
         right_before_in       = right_last_ff;
         right_last_in         = right_sample;
      end
      if (req_take) begin
         in_valid_in            = 1'b1;
         in_word_in.left_hdr    = req_chan.left_hdr;
         in_word_in.right_hdr   = req_chan.right_hdr;
         in_word_in.packed_byte = req_chan.packed_byte;
      end
   end

   // Control state and history
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         left_last_ff    <= '0;
         left_before_ff  <= '0;
         right_last_ff   <= '0;
         right_before_ff <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         left_last_ff    <= left_last_in;
         left_before_ff  <= left_before_in;
         right_last_ff   <= right_last_in;
         right_before_ff <= right_before_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.left_pcm  = out_word_ff.left_pcm;
   assign rsp_chan.right_pcm = out_word_ff.right_pcm;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the stereo XA-ADPCM nibble decoder
// A short table of hand-picked words (reset state, shift extremes, unused
// header bits, saturation, every filter) is followed by random header blocks
// and noise words. Both channels idle at random. Each output field is checked against
// the table value if given, else a behavioural decoder that tracks its own history.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int NUM_DIRECTED = 18;
   localparam int RANDOM_WORDS = 1332;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 8;

   // Filter gains on the last and the one-before-last output
   localparam int LAST_GAIN  [4] = '{0, 60, 115, 98};
   localparam int PRIOR_GAIN [4] = '{0, 0, -52, -55};

   typedef struct packed {
      logic [7:0]         lh;
      logic [7:0]         rh;
      logic [7:0]         pb;
      bit                 known;
      logic signed [15:0] l;
      logic signed [15:0] r;
   } directed_row_type;

   typedef struct {
      bit                     known;
      xaad_pkg::rsp_word_type pcm;
   } pcm_hint_type;

   logic clock = 1'b0;
   logic reset;

   xaad_req_if req_if ();
   xaad_rsp_if rsp_if ();

   xa_adpcm_stereo_nibble_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #6 clock = ~clock;

   // Predictor history, per channel
   logic signed [15:0] l_last  = '0;
   logic signed [15:0] l_prior = '0;
   logic signed [15:0] r_last  = '0;
   logic signed [15:0] r_prior = '0;

   xaad_pkg::rsp_word_type pcm_pair_q [$];
   pcm_hint_type           pcm_hint_q [$];
   int                     error_count = 0;
   int                     idle_cycles = 0;
   int                     hold_left   = 0;
   bit                     calm        = 1'b0;

   // Hand-picked words; filter 0 rows carry their value, the rest go to the predictor
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{8'h00, 8'h00, 8'h00, 1'b1,  16'sd0,      16'sd0},      // straight after reset
      '{8'h00, 8'h00, 8'h87, 1'b1,  16'sd28672, -16'sd32768},  // nibble extremes
      '{8'h0f, 8'h0f, 8'h78, 1'b1, -16'sd1,      16'sd0},      // large shift
      '{8'h0c, 8'h0d, 8'hf1, 1'b1,  16'sd1,     -16'sd1},
      '{8'hc0, 8'hc0, 8'h44, 1'b1,  16'sd16384,  16'sd16384},  // unused header bits
      '{8'h0e, 8'h0e, 8'h77, 1'b1,  16'sd1,      16'sd1},
      '{8'h10, 8'h10, 8'h77, 1'b0,  16'sd0,      16'sd0},
      '{8'h10, 8'h10, 8'h77, 1'b0,  16'sd0,      16'sd0},      // positive overflow
      '{8'h20, 8'h20, 8'h77, 1'b0,  16'sd0,      16'sd0},
      '{8'h30, 8'h30, 8'h00, 1'b0,  16'sd0,      16'sd0},
      '{8'h00, 8'h00, 8'h88, 1'b1, -16'sd32768, -16'sd32768},
      '{8'h10, 8'h10, 8'h88, 1'b0,  16'sd0,      16'sd0},      // negative overflow
      '{8'h20, 8'h30, 8'h88, 1'b0,  16'sd0,      16'sd0},
      '{8'h2f, 8'h3f, 8'h00, 1'b0,  16'sd0,      16'sd0},
      '{8'h3b, 8'h25, 8'h5a, 1'b0,  16'sd0,      16'sd0},
      '{8'hff, 8'hff, 8'hff, 1'b0,  16'sd0,      16'sd0},
      '{8'h13, 8'h26, 8'he9, 1'b0,  16'sd0,      16'sd0},
      '{8'hb1, 8'h72, 8'h3c, 1'b0,  16'sd0,      16'sd0}
   };

   // One channel: scaled nibble plus rounded prediction, clamped to 16 bits
   function automatic logic signed [15:0] decode_channel(
      input logic [7:0]         hdr,
      input logic [3:0]         nib,
      input logic signed [15:0] last,
      input logic signed [15:0] prior
   );
      int shamt;
      int filt;
      int scaled;
      int pred;
      int total;
      shamt  = int'(hdr[3:0]);
      filt   = int'(hdr[5:4]);
      scaled = int'($signed(nib)) * 4096;
      scaled = scaled >>> shamt;
      pred   = LAST_GAIN[filt] * int'(last) + PRIOR_GAIN[filt] * int'(prior);
      total  = scaled + (pred + 32) / 64;   // int divide truncates toward zero
      if (total > 32767)  total = 32767;
      if (total < -32768) total = -32768;
      return 16'(total);
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Offer one word after a random gap and hold it until taken
   task automatic send_word(input xaad_pkg::req_word_type w, input pcm_hint_type hint);
      int gap;
      gap = pick_gap();
      pcm_hint_q.push_back(hint);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.left_hdr    <= w.left_hdr;
      req_if.right_hdr   <= w.right_hdr;
      req_if.packed_byte <= w.packed_byte;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Output side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         hold_left = pick_gap();
      end
   end

   // Predict on every accepted input word, check every accepted output word
   always @(posedge clock) begin
      pcm_hint_type           hint;
      xaad_pkg::rsp_word_type pair;
      xaad_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            hint = pcm_hint_q.pop_front();
            pair.left_pcm  = decode_channel(req_if.left_hdr, req_if.packed_byte[3:0],
                                            l_last, l_prior);
            pair.right_pcm = decode_channel(req_if.right_hdr, req_if.packed_byte[7:4],
                                            r_last, r_prior);
            l_prior = l_last;
            l_last  = pair.left_pcm;
            r_prior = r_last;
            r_last  = pair.right_pcm;
            pcm_pair_q.push_back(hint.known ? hint.pcm : pair);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pcm_pair_q.size() == 0) begin
               report_mismatch($sformatf("output word %0d/%0d with none expected",
                                         rsp_if.left_pcm, rsp_if.right_pcm));
            end else begin
               want = pcm_pair_q.pop_front();
               if (rsp_if.left_pcm !== want.left_pcm)
                  report_mismatch($sformatf("left_pcm got %0d want %0d",
                                            rsp_if.left_pcm, want.left_pcm));
               if (rsp_if.right_pcm !== want.right_pcm)
                  report_mismatch($sformatf("right_pcm got %0d want %0d",
                                            rsp_if.right_pcm, want.right_pcm));
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      xaad_pkg::req_word_type w;
      pcm_hint_type           hint;
      logic [7:0]             lh;
      logic [7:0]             rh;
      int                     run;
      int                     sent;

      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.left_hdr    = '0;
      req_if.right_hdr   = '0;
      req_if.packed_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      calm = 1'b1;
      foreach (directed_rows[i]) begin
         w.left_hdr         = directed_rows[i].lh;
         w.right_hdr        = directed_rows[i].rh;
         w.packed_byte      = directed_rows[i].pb;
         hint.known         = directed_rows[i].known;
         hint.pcm.left_pcm  = directed_rows[i].l;
         hint.pcm.right_pcm = directed_rows[i].r;
         send_word(w, hint);
         if (i == NUM_DIRECTED / 2) calm = 1'b0;
      end

      // random: mostly sound-group style blocks sharing headers, some noise
      hint.known = 1'b0;
      hint.pcm   = '0;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 9) < 8) begin
            lh  = 8'($urandom);
            rh  = 8'($urandom);
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 27) : 28;
            repeat (run) begin
               w.left_hdr    = lh;
               w.right_hdr   = rh;
               w.packed_byte = 8'($urandom);
               send_word(w, hint);
               sent++;
            end
         end else begin
            run = $urandom_range(1, 8);
            repeat (run) begin
               w.left_hdr    = 8'($urandom);
               w.right_hdr   = 8'($urandom);
               w.packed_byte = 8'($urandom);
               send_word(w, hint);
               sent++;
            end
         end
      end
      req_if.valid <= 1'b0;

      // drain
      while (pcm_pair_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
